/* rtl/sdsa_pkg.sv */
// Shared types and constants of the signed decimal string adder.
package sdsa_pkg;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [4:0] RADIX    = 5'd10;

	localparam logic [1:0] CLS_SIGN  = 2'd0;
	localparam logic [1:0] CLS_DOT   = 2'd1;
	localparam logic [1:0] CLS_DIGIT = 2'd2;
	localparam logic [1:0] CLS_BAD   = 2'd3;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_SYNTAX = 2'd1;
	localparam logic [1:0] ST_DIGITS = 2'd2;
	localparam logic [1:0] ST_ORDER  = 2'd3;

	typedef struct packed {
		logic       kind;
		logic [1:0] cls;
		logic       minus;
		logic [3:0] digit;
		logic       last;
	} item_t;
endpackage

/* rtl/sdsa_if.sv */
// Valid/ready channel interfaces for operand characters and result characters.
interface sdsa_in_if;
	logic       valid;
	logic       ready;
	logic       kind;
	logic [7:0] char_code;
	logic       last_char;
	modport source (output valid, kind, char_code, last_char, input ready);
	modport sink (input valid, kind, char_code, last_char, output ready);
endinterface

interface sdsa_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_char;
	logic       out_last;
	logic [1:0] status;
	modport source (output valid, out_char, out_last, status, input ready);
	modport sink (input valid, out_char, out_last, status, output ready);
endinterface

/* rtl/sdsa_front.sv */
// Front end: accepts operand characters and classifies them.
module sdsa_front (
	sdsa_in_if.sink          operand,
	output sdsa_pkg::item_t  item,
	output logic             push,
	input  logic             q_ready
);
	import sdsa_pkg::*;

	assign operand.ready = q_ready;
	assign push = operand.valid && q_ready;

	always_comb begin
		item.kind  = operand.kind;
		item.last  = operand.last_char;
		item.minus = (operand.char_code == CH_MINUS);
		item.digit = operand.char_code[3:0];
		if (operand.char_code == CH_PLUS || operand.char_code == CH_MINUS) begin
			item.cls = CLS_SIGN;
		end else if (operand.char_code == CH_DOT) begin
			item.cls = CLS_DOT;
		end else if (operand.char_code >= CH_ZERO && operand.char_code <= CH_ZERO + 8'd9) begin
			item.cls = CLS_DIGIT;
		end else begin
			item.cls = CLS_BAD;
		end
	end
endmodule

/* rtl/sdsa_queue.sv */
// Two-entry queue of classified items between front and back.
module sdsa_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  sdsa_pkg::item_t wr_item,
	input  logic            push,
	output logic            ready,
	output sdsa_pkg::item_t rd_item,
	output logic            valid,
	input  logic            pop
);
	import sdsa_pkg::*;

	item_t      mem_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;

	assign ready   = (cnt_q != 2'd2);
	assign valid   = (cnt_q != 2'd0);
	assign rd_item = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wp_q <= ~wp_q;
			end
			if (pop) begin
				rp_q <= ~rp_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= wr_item;
		end
	end
endmodule

/* rtl/sdsa_back.sv */
// Back end: parses to BCD stores; compares (signs differ), adds, emits digit by digit.
module sdsa_back #(
	parameter int WHOLE_DIGITS    = 16,
	parameter int FRACTION_DIGITS = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	input  sdsa_pkg::item_t item,
	input  logic            q_valid,
	output logic            pop,
	sdsa_out_if.source      result
);
	import sdsa_pkg::*;

	localparam int L  = WHOLE_DIGITS + FRACTION_DIGITS;
	localparam int IW = $clog2(L + 1);
	localparam int SW = (L > 1) ? $clog2(L) : 1;
	localparam logic [IW-1:0] IDX_F   = IW'(FRACTION_DIGITS);
	localparam logic [IW-1:0] IDX_FM1 = IW'(FRACTION_DIGITS - 1);
	localparam logic [IW-1:0] IDX_W   = IW'(WHOLE_DIGITS);
	localparam logic [IW-1:0] IDX_TOP = IW'(L - 1);
	localparam logic [IW-1:0] IDX_L   = IW'(L);

	localparam logic [2:0] S_PARSE = 3'd0;
	localparam logic [2:0] S_ERR   = 3'd1;
	localparam logic [2:0] S_CMP   = 3'd2;
	localparam logic [2:0] S_ADD   = 3'd3;
	localparam logic [2:0] S_EMIT  = 3'd4;

	localparam logic [1:0] PH_START = 2'd0;
	localparam logic [1:0] PH_SIGN  = 2'd1;
	localparam logic [1:0] PH_DIGIT = 2'd2;
	localparam logic [1:0] PH_SKIP  = 2'd3;

	localparam logic [1:0] CMP_EQ = 2'd0;
	localparam logic [1:0] CMP_GT = 2'd1;
	localparam logic [1:0] CMP_LT = 2'd2;

	localparam logic [1:0] E_SIGN  = 2'd0;
	localparam logic [1:0] E_WHOLE = 2'd1;
	localparam logic [1:0] E_DOT   = 2'd2;
	localparam logic [1:0] E_FRAC  = 2'd3;

	localparam logic [1:0] ACT_NONE = 2'd0;
	localparam logic [1:0] ACT_ERR  = 2'd1;
	localparam logic [1:0] ACT_CALC = 2'd2;

	logic [3:0]    a_q [L];
	logic [3:0]    b_q [L];
	logic          fneg_q, sneg_q, fdone_q, dot_q;
	logic [1:0]    phase_q, perr_q;
	logic [IW-1:0] wcnt_q, fcnt_q;
	logic [2:0]    st_q;
	logic [IW-1:0] idx_q, top_q, low_q;
	logic [1:0]    cmp_q, esub_q;
	logic          carry_q, nz_q, neg_q, topd_q;
	logic          o_valid_q, o_last_q;
	logic [7:0]    o_char_q;
	logic [1:0]    o_status_q;

	logic          dot_n, fdone_n, fneg_n, sneg_n;
	logic [1:0]    phase_n, perr_n, act;
	logic [IW-1:0] wcnt_n, fcnt_n, wr_idx;
	logic          shift_en, wr_en;
	logic          slot_free;
	logic          o_set, emit_end;

	logic [3:0]    ad, bd, big, sml, rdig, edig;
	logic [4:0]    sum5;
	logic          cout;

	function automatic logic [1:0] note(input logic [1:0] cur, input logic [1:0] code);
		return (cur == ST_OK) ? code : cur;
	endfunction

	assign pop       = q_valid && (st_q == S_PARSE);
	assign slot_free = !o_valid_q || result.ready;
	assign emit_end  = (esub_q == E_WHOLE && idx_q == IDX_F && low_q == IDX_F) ||
	                   (esub_q == E_FRAC && idx_q == low_q);
	assign o_set     = slot_free && ((st_q == S_ERR) ||
	                   (st_q == S_EMIT && (esub_q != E_SIGN || (nz_q && neg_q))));

	assign result.valid    = o_valid_q;
	assign result.out_char = o_char_q;
	assign result.out_last = o_last_q;
	assign result.status   = o_status_q;

	always_comb begin
		phase_n  = phase_q;
		dot_n    = dot_q;
		wcnt_n   = wcnt_q;
		fcnt_n   = fcnt_q;
		perr_n   = perr_q;
		fdone_n  = fdone_q;
		fneg_n   = fneg_q;
		sneg_n   = sneg_q;
		shift_en = 1'b0;
		wr_en    = 1'b0;
		wr_idx   = IDX_FM1 - fcnt_q;
		act      = ACT_NONE;
		if (pop) begin
			if (item.kind != fdone_q) begin
				perr_n = note(perr_n, ST_ORDER);
				if (item.kind && item.last) begin
					act = ACT_ERR;
				end
			end else begin
				if (phase_q != PH_SKIP) begin
					unique case (item.cls)
						CLS_SIGN: begin
							if (phase_q == PH_START) begin
								if (item.kind) begin
									sneg_n = item.minus;
								end else begin
									fneg_n = item.minus;
								end
								phase_n = PH_SIGN;
							end else begin
								perr_n  = note(perr_n, ST_SYNTAX);
								phase_n = PH_SKIP;
							end
						end
						CLS_DOT: begin
							if (phase_q == PH_DIGIT && !dot_q) begin
								dot_n = 1'b1;
							end else begin
								perr_n  = note(perr_n, ST_SYNTAX);
								phase_n = PH_SKIP;
							end
						end
						CLS_DIGIT: begin
							phase_n = PH_DIGIT;
							if (!dot_q) begin
								if (item.digit == 4'd0 && wcnt_q == '0) begin
									phase_n = PH_DIGIT;
								end else if (wcnt_q >= IDX_W) begin
									perr_n  = note(perr_n, ST_DIGITS);
									phase_n = PH_SKIP;
								end else begin
									shift_en = 1'b1;
									wcnt_n   = wcnt_q + 1'b1;
								end
							end else if (fcnt_q >= IDX_F) begin
								perr_n  = note(perr_n, ST_DIGITS);
								phase_n = PH_SKIP;
							end else begin
								wr_en  = 1'b1;
								fcnt_n = fcnt_q + 1'b1;
							end
						end
						default: begin
							perr_n  = note(perr_n, ST_SYNTAX);
							phase_n = PH_SKIP;
						end
					endcase
				end
				if (item.last) begin
					if (phase_n != PH_SKIP &&
					    (phase_n != PH_DIGIT || (dot_n && fcnt_n == '0))) begin
						perr_n = note(perr_n, ST_SYNTAX);
					end
					phase_n = PH_START;
					dot_n   = 1'b0;
					wcnt_n  = '0;
					fcnt_n  = '0;
					if (!item.kind) begin
						fdone_n = 1'b1;
					end else begin
						act = (perr_n != ST_OK) ? ACT_ERR : ACT_CALC;
					end
				end
			end
		end
	end

	always_comb begin
		ad   = a_q[idx_q[SW-1:0]];
		bd   = b_q[idx_q[SW-1:0]];
		big  = (cmp_q == CMP_GT) ? ad : bd;
		sml  = (cmp_q == CMP_GT) ? bd : ad;
		if (fneg_q == sneg_q) begin
			sum5 = {1'b0, ad} + {1'b0, bd} + {4'd0, carry_q};
			cout = (sum5 >= RADIX);
			rdig = cout ? 4'(sum5 - RADIX) : sum5[3:0];
		end else begin
			sum5 = {1'b0, big} - {1'b0, sml} - {4'd0, carry_q};
			cout = sum5[4];
			rdig = cout ? 4'(sum5 + RADIX) : sum5[3:0];
		end
		edig = (idx_q == IDX_L) ? {3'd0, topd_q} : ad;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			o_valid_q <= 1'b0;
		end else if (o_set) begin
			o_valid_q <= 1'b1;
		end else if (result.ready) begin
			o_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < L; i++) begin
				a_q[i] <= 4'd0;
				b_q[i] <= 4'd0;
			end
			fneg_q     <= 1'b0;
			sneg_q     <= 1'b0;
			fdone_q    <= 1'b0;
			dot_q      <= 1'b0;
			phase_q    <= PH_START;
			perr_q     <= ST_OK;
			wcnt_q     <= '0;
			fcnt_q     <= '0;
			st_q       <= S_PARSE;
			idx_q      <= '0;
			top_q      <= '0;
			low_q      <= '0;
			cmp_q      <= CMP_EQ;
			esub_q     <= E_SIGN;
			carry_q    <= 1'b0;
			nz_q       <= 1'b0;
			neg_q      <= 1'b0;
			topd_q     <= 1'b0;
			o_last_q   <= 1'b0;
			o_char_q   <= 8'd0;
			o_status_q <= ST_OK;
		end else begin
			unique case (st_q)
				S_PARSE: begin
					phase_q <= phase_n;
					dot_q   <= dot_n;
					wcnt_q  <= wcnt_n;
					fcnt_q  <= fcnt_n;
					perr_q  <= perr_n;
					fdone_q <= fdone_n;
					fneg_q  <= fneg_n;
					sneg_q  <= sneg_n;
					if (shift_en) begin
						for (int i = L - 1; i > FRACTION_DIGITS; i--) begin
							if (item.kind) begin
								b_q[i] <= b_q[i-1];
							end else begin
								a_q[i] <= a_q[i-1];
							end
						end
						if (item.kind) begin
							b_q[FRACTION_DIGITS] <= item.digit;
						end else begin
							a_q[FRACTION_DIGITS] <= item.digit;
						end
					end
					if (wr_en) begin
						if (item.kind) begin
							b_q[wr_idx[SW-1:0]] <= item.digit;
						end else begin
							a_q[wr_idx[SW-1:0]] <= item.digit;
						end
					end
					carry_q <= 1'b0;
					cmp_q   <= CMP_EQ;
					top_q   <= IDX_F;
					low_q   <= IDX_F;
					nz_q    <= 1'b0;
					topd_q  <= 1'b0;
					if (act == ACT_ERR) begin
						st_q <= S_ERR;
					end else if (act == ACT_CALC) begin
						if (fneg_n == sneg_n) begin
							st_q  <= S_ADD;
							idx_q <= '0;
						end else begin
							st_q  <= S_CMP;
							idx_q <= IDX_TOP;
						end
					end
				end
				S_ERR: begin
					if (slot_free) begin
						o_char_q   <= 8'd0;
						o_last_q   <= 1'b1;
						o_status_q <= perr_q;
						for (int i = 0; i < L; i++) begin
							a_q[i] <= 4'd0;
							b_q[i] <= 4'd0;
						end
						fneg_q  <= 1'b0;
						sneg_q  <= 1'b0;
						fdone_q <= 1'b0;
						perr_q  <= ST_OK;
						phase_q <= PH_START;
						dot_q   <= 1'b0;
						wcnt_q  <= '0;
						fcnt_q  <= '0;
						st_q    <= S_PARSE;
					end
				end
				S_CMP: begin
					if (cmp_q == CMP_EQ && ad != bd) begin
						cmp_q <= (ad > bd) ? CMP_GT : CMP_LT;
					end
					if (idx_q == '0) begin
						st_q <= S_ADD;
					end else begin
						idx_q <= idx_q - 1'b1;
					end
				end
				S_ADD: begin
					a_q[idx_q[SW-1:0]] <= rdig;
					carry_q <= cout;
					if (rdig != 4'd0 || (idx_q == IDX_TOP && fneg_q == sneg_q && cout)) begin
						nz_q <= 1'b1;
					end
					if (rdig != 4'd0) begin
						if (idx_q >= IDX_F) begin
							top_q <= idx_q;
						end else if (low_q == IDX_F) begin
							low_q <= idx_q;
						end
					end
					if (fneg_q == sneg_q) begin
						neg_q <= fneg_q;
					end else begin
						neg_q <= (cmp_q == CMP_GT) ? fneg_q : ((cmp_q == CMP_LT) ? sneg_q : 1'b0);
					end
					if (idx_q == IDX_TOP) begin
						st_q <= S_EMIT;
						esub_q <= E_SIGN;
						if (fneg_q == sneg_q && cout) begin
							topd_q <= 1'b1;
							idx_q  <= IDX_L;
						end else if (rdig != 4'd0) begin
							idx_q <= idx_q;
						end else begin
							idx_q <= top_q;
						end
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				S_EMIT: begin
					if (slot_free) begin
						o_status_q <= ST_OK;
						o_last_q   <= emit_end;
						case (esub_q)
							E_SIGN: begin
								esub_q <= E_WHOLE;
								if (nz_q && neg_q) begin
									o_char_q <= CH_MINUS;
								end
							end
							E_WHOLE: begin
								o_char_q <= CH_ZERO + {4'd0, edig};
								if (idx_q == IDX_F) begin
									if (low_q != IDX_F) begin
										esub_q <= E_DOT;
									end
								end else begin
									idx_q <= idx_q - 1'b1;
								end
							end
							E_DOT: begin
								o_char_q <= CH_DOT;
								esub_q   <= E_FRAC;
								idx_q    <= IDX_FM1;
							end
							default: begin
								o_char_q <= CH_ZERO + {4'd0, edig};
								if (idx_q != low_q) begin
									idx_q <= idx_q - 1'b1;
								end
							end
						endcase
						if (emit_end) begin
							for (int i = 0; i < L; i++) begin
								a_q[i] <= 4'd0;
								b_q[i] <= 4'd0;
							end
							fneg_q  <= 1'b0;
							sneg_q  <= 1'b0;
							fdone_q <= 1'b0;
							perr_q  <= ST_OK;
							st_q    <= S_PARSE;
						end
					end
				end
				default: begin
					st_q <= S_PARSE;
				end
			endcase
		end
	end

	a_no_pop_busy: assert property (@(posedge clk) disable iff (!arst_n)
		st_q != S_PARSE |-> !pop) else $error("item taken while busy");
	a_err_item: assert property (@(posedge clk) disable iff (!arst_n)
		o_valid_q && o_char_q == 8'd0 |-> o_last_q && o_status_q != ST_OK)
		else $error("bad error result");
	a_cmp_signs: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == S_CMP |-> fneg_q != sneg_q) else $error("compare with equal signs");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		o_valid_q && !result.ready |=> $stable(o_char_q) && o_valid_q)
		else $error("result changed while stalled");
endmodule

/* rtl/signed_decimal_string_adder_core.sv */
// Signed decimal string adder: front classifier, item queue and BCD back end.
// Characters are parsed one per cycle while the back end is in its parse state; after the final B character
// it emits one error result if a fault was noted; else it compares (signs differ only) and adds digit by digit
// over all L = WHOLE_DIGITS + FRACTION_DIGITS digits, offers the sign slot, then emits the result characters.
// Operand characters are not parsed while a result is computed or emitted; only the two-entry queue takes them.
// Reset: arst_n asynchronously clears stores, queue, state and the output register.
module signed_decimal_string_adder_core #(
	parameter int WHOLE_DIGITS    = 16,
	parameter int FRACTION_DIGITS = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	sdsa_in_if.sink    operand,
	sdsa_out_if.source result
);
	import sdsa_pkg::*;

	item_t f_item, q_item;
	logic  push, q_ready, q_valid, pop;

	sdsa_front u_front (
		.operand (operand),
		.item    (f_item),
		.push    (push),
		.q_ready (q_ready)
	);

	sdsa_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_item (f_item),
		.push    (push),
		.ready   (q_ready),
		.rd_item (q_item),
		.valid   (q_valid),
		.pop     (pop)
	);

	sdsa_back #(
		.WHOLE_DIGITS    (WHOLE_DIGITS),
		.FRACTION_DIGITS (FRACTION_DIGITS)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.item    (q_item),
		.q_valid (q_valid),
		.pop     (pop),
		.result  (result)
	);
endmodule

/* tb/sdsa_tb_if.sv */
// Testbench-side channel interfaces are those of the RTL; this file holds the shared item types.
package sdsa_tb_pkg;
	typedef struct {
		logic       kind;
		logic [7:0] ch;
		logic       last;
	} op_char_t;

	typedef struct {
		logic [7:0] ch;
		logic       last;
		logic [1:0] status;
	} sum_char_t;
endpackage

/* tb/signed_decimal_string_adder_core_tb.sv */
// Testbench of the signed decimal string adder: directed and random operand strings, predicted sums and error results.
module signed_decimal_string_adder_core_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import sdsa_pkg::*;
	import sdsa_tb_pkg::*;

	localparam int WD = 16;
	localparam int FD = 16;
	localparam int SL = WD + FD;
	localparam int LIMIT = 2000000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	always #6 clk = ~clk;

	sdsa_in_if  operand ();
	sdsa_out_if result ();

	signed_decimal_string_adder_core #(.WHOLE_DIGITS(WD), .FRACTION_DIGITS(FD)) dut (
		.clk(clk), .arst_n(arst_n), .operand(operand.sink), .result(result.source)
	);

	// predictor state
	logic [3:0] a_bcd [SL];
	logic [3:0] b_bcd [SL];
	logic       a_neg, b_neg, dot_seen, a_done;
	logic [1:0] phase, err;
	int         n_whole, n_frac;

	sum_char_t  sum_q [$];
	int         errors = 0;
	int         cycles = 0;
	bit         quiet = 0;
	int         items_sent = 0;

	task automatic report(input string what);
		$display("mismatch: %s", what);
		errors++;
	endtask

	function automatic void clear_sum_state();
		for (int i = 0; i < SL; i++) begin
			a_bcd[i] = 0;
			b_bcd[i] = 0;
		end
		a_neg = 0; b_neg = 0; a_done = 0; err = ST_OK;
		phase = 0; dot_seen = 0; n_whole = 0; n_frac = 0;
	endfunction

	function automatic void flag(input logic [1:0] code);
		if (err == ST_OK) err = code;
	endfunction

	function automatic void push_sum(input logic [7:0] c);
		sum_char_t s;
		s.ch = c; s.last = 0; s.status = ST_OK;
		sum_q.push_back(s);
	endfunction

	function automatic void take_char(input logic which, input logic [7:0] c);
		logic [3:0] d;
		if (phase == 3) return;
		if (c == CH_PLUS || c == CH_MINUS) begin
			if (phase == 0) begin
				if (which) b_neg = (c == CH_MINUS);
				else a_neg = (c == CH_MINUS);
				phase = 1;
			end else begin
				flag(ST_SYNTAX); phase = 3;
			end
		end else if (c == CH_DOT) begin
			if (phase == 2 && !dot_seen) dot_seen = 1;
			else begin
				flag(ST_SYNTAX); phase = 3;
			end
		end else if (c >= CH_ZERO && c <= CH_ZERO + 8'd9) begin
			d = 4'(c - CH_ZERO);
			phase = 2;
			if (!dot_seen) begin
				if (d == 0 && n_whole == 0) return;
				if (n_whole >= WD) begin
					flag(ST_DIGITS); phase = 3; return;
				end
				for (int i = SL - 1; i > FD; i--) begin
					if (which) b_bcd[i] = b_bcd[i-1];
					else a_bcd[i] = a_bcd[i-1];
				end
				if (which) b_bcd[FD] = d;
				else a_bcd[FD] = d;
				n_whole++;
			end else begin
				if (n_frac >= FD) begin
					flag(ST_DIGITS); phase = 3; return;
				end
				if (which) b_bcd[FD-1-n_frac] = d;
				else a_bcd[FD-1-n_frac] = d;
				n_frac++;
			end
		end else begin
			flag(ST_SYNTAX); phase = 3;
		end
	endfunction

	function automatic void predict_sum();
		logic [3:0] r [SL+1];
		logic neg, carry, nz;
		int cmp, top, low, dv;
		for (int i = 0; i <= SL; i++) r[i] = 0;
		neg = 0;
		if (a_neg == b_neg) begin
			carry = 0;
			for (int i = 0; i < SL; i++) begin
				dv = a_bcd[i] + b_bcd[i] + carry;
				carry = dv >= 10;
				r[i] = 4'(carry ? dv - 10 : dv);
			end
			r[SL] = {3'b000, carry};
			neg = a_neg;
		end else begin
			cmp = 0;
			for (int i = SL - 1; i >= 0 && cmp == 0; i--)
				if (a_bcd[i] != b_bcd[i]) cmp = (a_bcd[i] > b_bcd[i]) ? 1 : -1;
			if (cmp != 0) begin
				carry = 0;
				for (int i = 0; i < SL; i++) begin
					dv = (cmp > 0) ? a_bcd[i] - b_bcd[i] - carry : b_bcd[i] - a_bcd[i] - carry;
					carry = dv < 0;
					r[i] = 4'(dv < 0 ? dv + 10 : dv);
				end
				neg = (cmp > 0) ? a_neg : b_neg;
			end
		end
		nz = 0;
		for (int i = 0; i <= SL; i++) if (r[i] != 0) nz = 1;
		top = FD;
		for (int i = SL; i > FD; i--) if (r[i] != 0) begin top = i; break; end
		low = FD;
		for (int i = 0; i < FD; i++) if (r[i] != 0) begin low = i; break; end
		if (nz && neg) push_sum(CH_MINUS);
		for (int i = top; i >= FD; i--) push_sum(CH_ZERO + 8'(r[i]));
		if (low < FD) begin
			push_sum(CH_DOT);
			for (int i = FD - 1; i >= low; i--) push_sum(CH_ZERO + 8'(r[i]));
		end
		sum_q[$].last = 1;
	endfunction

	function automatic void push_error();
		sum_char_t s;
		s.ch = 0; s.last = 1; s.status = err;
		sum_q.push_back(s);
	endfunction

	function automatic void predict(input op_char_t it);
		if (it.kind != a_done) begin
			flag(ST_ORDER);
			if (it.kind && it.last) begin
				push_error();
				clear_sum_state();
			end
			return;
		end
		take_char(it.kind, it.ch);
		if (!it.last) return;
		if (phase != 3 && (phase != 2 || (dot_seen && n_frac == 0))) flag(ST_SYNTAX);
		phase = 0; dot_seen = 0; n_whole = 0; n_frac = 0;
		if (!it.kind) begin
			a_done = 1;
			return;
		end
		if (err != ST_OK) push_error();
		else predict_sum();
		clear_sum_state();
	endfunction

	function automatic bit idle_now();
		return !quiet && ($urandom_range(99) < 15);
	endfunction

	task automatic send_char(input logic k, input logic [7:0] c, input logic l);
		op_char_t it;
		if (idle_now()) begin
			operand.valid <= 1'b0;
			do @(posedge clk); while (idle_now());
		end
		operand.valid <= 1'b1;
		operand.kind <= k;
		operand.char_code <= c;
		operand.last_char <= l;
		do @(posedge clk); while (!operand.ready);
		it.kind = k; it.ch = c; it.last = l;
		predict(it);
		items_sent++;
	endtask

	task automatic send_string(input logic k, input string s);
		for (int i = 0; i < s.len(); i++)
			send_char(k, s[i], i == s.len() - 1);
	endtask

	task automatic send_pair(input string a, input string b);
		send_string(0, a);
		send_string(1, b);
	endtask

	function automatic string rand_number(input int wmax, input int fmax);
		string s;
		int w, f;
		s = "";
		case ($urandom_range(3))
			0: s = "-";
			1: s = "+";
			default: ;
		endcase
		w = $urandom_range(1, wmax);
		if ($urandom_range(3) == 0) s = {s, "00"};
		for (int i = 0; i < w; i++) s = {s, string'(8'(CH_ZERO + $urandom_range(9)))};
		if (fmax > 0 && $urandom_range(1)) begin
			f = $urandom_range(1, fmax);
			s = {s, "."};
			for (int i = 0; i < f; i++) s = {s, string'(8'(CH_ZERO + $urandom_range(9)))};
		end
		return s;
	endfunction

	task automatic test_directed();
		send_pair("0", "0");
		send_pair("-0.0", "+0");
		send_pair("9999999999999999.9999999999999999", "9999999999999999.9999999999999999");
		send_pair("-1.5", "1.25");
		send_pair("000012.50", "-12.5");
		send_pair("12345678901234567", "1");
		send_pair("1.12345678901234567", "1");
		send_pair("1..2", "3");
		send_pair("+", "3");
		send_pair("5.", "3");
		send_pair("-.5", "3");
		send_pair("1-2", "7");
		send_char(1, "4", 1);
		send_char(0, "7", 1);
		send_char(0, "8", 0);
		send_char(1, "2", 1);
		send_pair("3a", "1");
		send_char(0, 8'hFF, 1);
		send_char(1, 8'h00, 1);
	endtask

	task automatic test_random_sums();
		for (int n = 0; n < 6; n++) begin
			if (n == 1) quiet = 1;
			if (n == 4) quiet = 0;
			send_pair(rand_number($urandom_range(1) ? 4 : 16, $urandom_range(1) ? 4 : 16),
				rand_number($urandom_range(1) ? 4 : 16, $urandom_range(1) ? 4 : 16));
		end
	endtask

	task automatic test_random_noise();
		for (int n = 0; n < 6; n++) begin
			case ($urandom_range(3))
				0: send_char($urandom_range(1), 8'($urandom), $urandom_range(1));
				1: send_pair(rand_number(18, 18), rand_number(3, 3));
				default: send_pair(rand_number(3, 2), rand_number(3, 2));
			endcase
		end
		send_pair("1", "1");
	endtask

	// result side: random stall, compare against oldest prediction
	always @(posedge clk) begin
		sum_char_t exp_c;
		if (arst_n) begin
			if (result.valid && result.ready) begin
				if (sum_q.size() == 0) report("result with nothing expected");
				else begin
					exp_c = sum_q.pop_front();
					if (result.out_char !== exp_c.ch)
						report($sformatf("out_char %h, want %h", result.out_char, exp_c.ch));
					if (result.out_last !== exp_c.last)
						report($sformatf("out_last %b, want %b", result.out_last, exp_c.last));
					if (result.status !== exp_c.status)
						report($sformatf("status %0d, want %0d", result.status, exp_c.status));
				end
			end
			result.ready <= quiet || ($urandom_range(99) >= 15);
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		operand.valid = 0;
		operand.kind = 0;
		operand.char_code = 0;
		operand.last_char = 0;
		result.ready = 0;
		clear_sum_state();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random_sums();
		test_random_noise();
		operand.valid <= 1'b0;
		while (sum_q.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (errors == 0) $display("TB_OK");
		else $display("TB_ERROR");
		$finish;
	end
endmodule

/* filelist.f */
rtl/sdsa_pkg.sv
rtl/sdsa_if.sv
rtl/sdsa_front.sv
rtl/sdsa_queue.sv
rtl/sdsa_back.sv
rtl/signed_decimal_string_adder_core.sv
tb/sdsa_tb_if.sv
tb/signed_decimal_string_adder_core_tb.sv
